// ===== rtl/core/rpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the reply packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // hard ceiling on payload length, checksum excluded
    localparam int unsigned PAYLOAD_LIMIT = 256;
    localparam logic [15:0] LEN_LIMIT     = 16'(PAYLOAD_LIMIT + 2);

    // register reset values
    localparam logic [15:0] START_CODE_RST  = 16'hEF01;
    localparam logic [31:0] DEV_ADDR_RST    = 32'hFFFF_FFFF;
    localparam logic [8:0]  MAX_PAYLOAD_RST = 9'd33;
    localparam logic [15:0] TIMEOUT_RST     = 16'd2000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_START_CODE  = 2'd0,
        REG_DEV_ADDR    = 2'd1,
        REG_MAX_PAYLOAD = 2'd2,
        REG_TIMEOUT     = 2'd3
    } rpd_reg_t;

    // input item modes
    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_START = 2'd2,
        MODE_NONE  = 2'd3
    } rpd_mode_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_CSUM = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } rpd_kind_t;

    // deframer phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_PID  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CSUM = 3'd5
    } rpd_phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } rpd_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [8:0] payload_count;
        logic [7:0] packet_id;
    } rpd_out_t;

endpackage

// ===== rtl/core/reply_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_packet_deframer_unit
// Deframes reply packets from a UART byte stream and watches for timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per item: a received byte, a timer tick or a start
//   command that arms the reply timeout. m_* carries at most one result beat
//   per item: a payload byte, frame good, checksum bad or timeout.
//   cfg_* writes the start code, device address, max payload and timeout
//   tick count; cfg_ready is always high. Write only while the block is idle.
// Throughput and datapath:
//   one item per cycle while s_ready is high; each result lands in the result
//   register, or in the skid entry while m_* stalls. All per-item work is one
//   pass of logic from the state registers into this two-entry output buffer.
// Stall:
//   while m_ready is low the skid entry takes one more result; s_ready drops
//   only once the skid entry is full.
// Reset:
//   aresetn (synchronous, active low) restores the default registers,
//   returns to start code hunting, disarms the timeout and empties the
//   output buffer. No clearing pass is needed.
// ----------------------------------------------------------------------------
module reply_packet_deframer_unit
    import rpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  rpd_in_t     s_data,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output rpd_out_t    m_data,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [15:0] start_code_reg;
    logic [31:0] dev_addr_reg;
    logic [8:0]  max_payload_reg;
    logic [15:0] timeout_reg;

    // deframer state
    rpd_phase_t  phase_reg,     phase_next;
    logic [15:0] window_reg,    window_next;
    logic [31:0] shift_reg,     shift_next;
    logic [1:0]  byte_idx_reg,  byte_idx_next;
    logic [7:0]  frame_id_reg,  frame_id_next;
    logic [8:0]  frame_len_reg, frame_len_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] sum_reg,       sum_next;
    logic [15:0] idle_reg,      idle_next;
    logic        armed_reg,     armed_next;

    // output buffer
    logic        out_valid_reg, skid_valid_reg;
    rpd_out_t    out_reg, skid_reg;

    // per-item result
    logic        res_valid;
    rpd_out_t    res;

    logic        s_acc, m_acc;
    logic [31:0] shifted;
    logic [15:0] len;
    logic [9:0]  len_max;
    logic [15:0] idle_inc;
    logic [8:0]  left_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_acc     = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign m_acc     = out_valid_reg && m_ready;

    assign shifted  = {shift_reg[23:0], s_data.rx_byte};
    assign len      = shifted[15:0];
    assign len_max  = {1'b0, max_payload_reg} + 10'd2;
    assign idle_inc = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign left_dec = (bytes_left_reg != 9'd0) ? bytes_left_reg - 9'd1 : bytes_left_reg;

    // next state and result for the item on s_data
    always_comb begin
        phase_next      = phase_reg;
        window_next     = window_reg;
        shift_next      = shift_reg;
        byte_idx_next   = byte_idx_reg;
        frame_id_next   = frame_id_reg;
        frame_len_next  = frame_len_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        idle_next       = idle_reg;
        armed_next      = armed_reg;
        res_valid       = 1'b0;
        res             = '0;

        unique case (rpd_mode_t'(s_data.mode))
            MODE_START: begin
                phase_next    = PH_HUNT;
                window_next   = '0;
                shift_next    = '0;
                byte_idx_next = '0;
                idle_next     = '0;
                armed_next    = 1'b1;
            end
            MODE_TICK: begin
                if (armed_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc >= timeout_reg) begin
                        armed_next    = 1'b0;
                        idle_next     = '0;
                        phase_next    = PH_HUNT;
                        window_next   = '0;
                        shift_next    = '0;
                        byte_idx_next = '0;
                        res_valid     = 1'b1;
                        res.kind      = KIND_TIMEOUT;
                    end
                end
            end
            MODE_BYTE: begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_HUNT: begin
                        window_next = {window_reg[7:0], s_data.rx_byte};
                        if ({window_reg[7:0], s_data.rx_byte} == start_code_reg) begin
                            phase_next    = PH_ADDR;
                            window_next   = '0;
                            shift_next    = '0;
                            byte_idx_next = '0;
                        end
                    end
                    PH_ADDR: begin
                        shift_next = shifted;
                        if (byte_idx_reg != 2'd3) begin
                            byte_idx_next = byte_idx_reg + 2'd1;
                        end else begin
                            phase_next    = (shifted == dev_addr_reg) ? PH_PID : PH_HUNT;
                            window_next   = '0;
                            shift_next    = '0;
                            byte_idx_next = '0;
                        end
                    end
                    PH_PID: begin
                        frame_id_next = s_data.rx_byte;
                        sum_next      = {8'd0, s_data.rx_byte};
                        phase_next    = PH_LEN;
                        shift_next    = '0;
                        byte_idx_next = '0;
                    end
                    PH_LEN: begin
                        shift_next = {16'd0, len};
                        if (byte_idx_reg == 2'd0) begin
                            byte_idx_next = 2'd1;
                        end else begin
                            shift_next    = '0;
                            byte_idx_next = '0;
                            if (len > LEN_LIMIT || len > {6'd0, len_max} || len < 16'd2) begin
                                phase_next  = PH_HUNT;
                                window_next = '0;
                            end else begin
                                frame_len_next  = len[8:0];
                                bytes_left_next = len[8:0] - 9'd2;
                                sum_next        = sum_reg + {8'd0, len[15:8]}
                                                + {8'd0, len[7:0]};
                                phase_next      = (len[8:0] == 9'd2) ? PH_CSUM : PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        sum_next         = sum_reg + {8'd0, s_data.rx_byte};
                        bytes_left_next  = left_dec;
                        if (left_dec == 9'd0) begin
                            phase_next    = PH_CSUM;
                            shift_next    = '0;
                            byte_idx_next = '0;
                        end
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = s_data.rx_byte;
                        res.packet_id    = frame_id_reg;
                    end
                    PH_CSUM: begin
                        shift_next = {16'd0, len};
                        if (byte_idx_reg == 2'd0) begin
                            byte_idx_next = 2'd1;
                        end else begin
                            phase_next    = PH_HUNT;
                            window_next   = '0;
                            shift_next    = '0;
                            byte_idx_next = '0;
                            res_valid     = 1'b1;
                            res.packet_id = frame_id_reg;
                            if (len != sum_reg) begin
                                res.kind = KIND_BAD_CSUM;
                            end else begin
                                armed_next        = 1'b0;
                                res.kind          = KIND_GOOD;
                                res.payload_count = frame_len_reg - 9'd2;
                            end
                        end
                    end
                    default: begin
                        phase_next    = PH_HUNT;
                        window_next   = '0;
                        shift_next    = '0;
                        byte_idx_next = '0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg  <= START_CODE_RST;
            dev_addr_reg    <= DEV_ADDR_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (rpd_reg_t'(cfg_index))
                REG_START_CODE:  start_code_reg  <= cfg_data[15:0];
                REG_DEV_ADDR:    dev_addr_reg    <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[8:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // deframer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            window_reg     <= '0;
            shift_reg      <= '0;
            byte_idx_reg   <= '0;
            frame_id_reg   <= '0;
            frame_len_reg  <= '0;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
            idle_reg       <= '0;
            armed_reg      <= 1'b0;
        end else if (s_acc) begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            shift_reg      <= shift_next;
            byte_idx_reg   <= byte_idx_next;
            frame_id_reg   <= frame_id_next;
            frame_len_reg  <= frame_len_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            idle_reg       <= idle_next;
            armed_reg      <= armed_next;
        end
    end

    // output buffer: result register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_acc) begin
                out_valid_reg  <= skid_valid_reg || (s_acc && res_valid);
                skid_valid_reg <= 1'b0;
            end else if (s_acc && res_valid) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= out_valid_reg;
            end
        end
    end

    // buffer payload
    always_ff @(posedge aclk) begin
        if (m_acc) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (s_acc && res_valid) begin
            if (out_valid_reg) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

`ifndef SYNTH
    // skid entry is only ever filled behind a full result register
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // a data phase always has payload bytes left to take
    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != 9'd0))
        else $error("data phase with no bytes left");

    // the idle counter only runs while a wait is armed
    a_idle_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (idle_reg != 16'd0) |-> armed_reg)
        else $error("idle ticks counted while not armed");

    // a timeout result disarms and returns to hunting
    a_timeout_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && res_valid && res.kind == KIND_TIMEOUT)
            |=> (!armed_reg && phase_reg == PH_HUNT))
        else $error("timeout left the wait armed");
`endif

endmodule
